/* hdl/u16d_pkg.sv */
`default_nettype none
package u16d_pkg;

	// status codes reported with the final item of a payload
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ODD       = 3'd1,
		ST_AFTER_NUL = 3'd2,
		ST_HIGH_END  = 3'd3,
		ST_BAD_PAIR  = 3'd4,
		ST_LONE_LOW  = 3'd5,
		ST_NO_NUL    = 3'd6
	} status_t;

	// surrogate ranges
	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [15:0] NUL_UNIT   = 16'h0000;

	// result queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        kind;
		status_t     status;
		logic        end_of_run;
	} out_item_t;

	// results produced by one accepted byte
	typedef struct packed {
		logic [1:0] count;
		out_item_t  r0;
		out_item_t  r1;
	} step_res_t;

	function automatic logic is_high(input logic [15:0] u);
		is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
	endfunction

	function automatic logic is_low(input logic [15:0] u);
		is_low = (u >= LOW_FIRST) && (u <= LOW_LAST);
	endfunction

endpackage
`default_nettype wire

/* hdl/utf16le_validating_decoder.sv */
// Validating little-endian UTF-16 decoder. Bytes of a NUL-terminated payload
// enter one per cycle, low byte of each unit first, with last_byte set on the
// final byte. Each accepted non-NUL code unit leaves as an item of kind 0; a
// surrogate pair leaves as two items once its low half is checked, and the
// unit closed by the last byte is checked but not sent. The last byte always
// yields one status item of kind 1; an odd length reports status 1 over any
// other error. After the first error nothing more is sent until that status.
// Each byte is decoded in the cycle it is accepted, its results going into a
// four-entry queue that drains one item per cycle unless stalled; a byte is
// taken every cycle while two slots are free, sustaining one byte per cycle.
`default_nettype none
module utf16le_validating_decoder import u16d_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_ready,
	input  wire in_item_t  byte_item,
	output logic           res_valid,
	input  wire logic      res_ready,
	output out_item_t      res_item
);

	logic      accept;
	logic      room;
	step_res_t step;

	assign byte_ready = room;
	assign accept     = byte_valid && byte_ready;

	// byte decoder and payload state
	u16d_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.res    (step)
	);

	// result queue
	u16d_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.wr        (step),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule
`default_nettype wire

/* hdl/u16d_step.sv */
`default_nettype none
module u16d_step import u16d_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire in_item_t  item,
	output step_res_t      res
);

	logic        phase_q, phase_n;
	logic [7:0]  hold_q, hold_n;
	logic [15:0] held_q, held_n;
	logic        hp_q, hp_n;
	logic        term_q, term_n;
	status_t     err_q, err_n;
	logic [15:0] unit;
	status_t     fin;

	assign unit = {item.data_byte, hold_q};

	// decode one byte against the current payload state
	always_comb begin
		phase_n = phase_q;
		hold_n  = hold_q;
		held_n  = held_q;
		hp_n    = hp_q;
		term_n  = term_q;
		err_n   = err_q;
		fin     = ST_OK;
		res     = '0;
		if (!phase_q) begin
			if (item.last_byte) begin
				// odd length wins over everything
				res.count = 2'd1;
				res.r0 = '{code_unit: 16'h0, kind: 1'b1, status: ST_ODD, end_of_run: 1'b1};
				phase_n = 1'b0;
				hold_n  = '0;
				held_n  = '0;
				hp_n    = 1'b0;
				term_n  = 1'b0;
				err_n   = ST_OK;
			end else begin
				hold_n  = item.data_byte;
				phase_n = 1'b1;
			end
		end else begin
			phase_n = 1'b0;
			hold_n  = '0;
			if (err_q == ST_OK) begin
				// a plain unit closing the payload matches no arm and is only checked
				if (hp_q) begin
					if (is_low(unit)) begin
						if (!item.last_byte) begin
							res.count = 2'd2;
							res.r0 = '{code_unit: held_q, kind: 1'b0, status: ST_OK,
								end_of_run: 1'b0};
							res.r1 = '{code_unit: unit, kind: 1'b0, status: ST_OK,
								end_of_run: 1'b1};
						end
						hp_n   = 1'b0;
						held_n = '0;
					end else begin
						err_n = ST_BAD_PAIR;
					end
				end else if (term_q) begin
					if (unit != NUL_UNIT) begin
						err_n = ST_AFTER_NUL;
					end
				end else if (unit == NUL_UNIT) begin
					term_n = 1'b1;
				end else if (is_high(unit)) begin
					held_n = unit;
					hp_n   = 1'b1;
				end else if (is_low(unit)) begin
					err_n = ST_LONE_LOW;
				end else if (!item.last_byte) begin
					res.count = 2'd1;
					res.r0 = '{code_unit: unit, kind: 1'b0, status: ST_OK, end_of_run: 1'b1};
				end
			end
			if (item.last_byte) begin
				// final status, first latched error first
				priority if (err_n != ST_OK) begin
					fin = err_n;
				end else if (hp_n) begin
					fin = ST_HIGH_END;
				end else if (!term_n) begin
					fin = ST_NO_NUL;
				end else begin
					fin = ST_OK;
				end
				res.count = 2'd1;
				res.r0 = '{code_unit: 16'h0, kind: 1'b1, status: fin, end_of_run: 1'b1};
				res.r1 = '0;
				hold_n = '0;
				held_n = '0;
				hp_n   = 1'b0;
				term_n = 1'b0;
				err_n  = ST_OK;
			end
		end
	end

	// payload state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			hold_q  <= '0;
			held_q  <= '0;
			hp_q    <= 1'b0;
			term_q  <= 1'b0;
			err_q   <= ST_OK;
		end else if (accept) begin
			phase_q <= phase_n;
			hold_q  <= hold_n;
			held_q  <= held_n;
			hp_q    <= hp_n;
			term_q  <= term_n;
			err_q   <= err_n;
		end
	end

endmodule
`default_nettype wire

/* hdl/u16d_outq.sv */
`default_nettype none
module u16d_outq import u16d_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire step_res_t wr,
	output logic           room,
	output logic           res_valid,
	input  wire logic      res_ready,
	output out_item_t      res_item
);

	out_item_t        entry_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic [1:0]       nwr;
	logic             pop;
	logic [QAW-1:0]   wr_ptr_1;

	assign nwr       = push ? wr.count : 2'd0;
	assign res_valid = (count_q != '0);
	assign pop       = res_valid && res_ready;
	assign res_item  = entry_q[rd_ptr_q];
	assign wr_ptr_1  = wr_ptr_q + QAW'(1);
	// two free slots cover the worst case of one byte
	assign room      = (count_q <= (QAW+1)'(QDEPTH - 2));

	// result storage
	always_ff @(posedge clk) begin
		if (nwr != 2'd0) begin
			entry_q[wr_ptr_q] <= wr.r0;
		end
		if (nwr == 2'd2) begin
			entry_q[wr_ptr_1] <= wr.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(nwr);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(nwr) - (QAW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

/* tb/u16d_stream_checker.sv */
`timescale 1ns / 1ps
module u16d_stream_checker import u16d_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	input  wire logic      byte_ready,
	input  wire in_item_t  byte_item,
	input  wire logic      res_valid,
	input  wire logic      res_ready,
	input  wire out_item_t res_item,
	output int             items_owed,
	output int             fails
);

	// decoder state as this checker tracks it
	logic        odd_phase;
	logic [7:0]  low_byte;
	logic [15:0] held_high;
	logic        high_waiting;
	logic        nul_seen;
	status_t     latched_err;

	out_item_t   due_items[$];
	out_item_t   want;

	task automatic restart_payload();
		odd_phase    = 1'b0;
		low_byte     = 8'h00;
		held_high    = 16'h0000;
		high_waiting = 1'b0;
		nul_seen     = 1'b0;
		latched_err  = ST_OK;
	endtask

	task automatic push_item(input logic [15:0] u, input logic k, input status_t st,
			input logic eor);
		out_item_t it;
		it.code_unit  = u;
		it.kind       = k;
		it.status     = st;
		it.end_of_run = eor;
		due_items.insert(due_items.size(), it);
	endtask

	// work out the items one accepted byte must produce
	task automatic decode_byte(input in_item_t bi);
		logic [15:0] u;
		logic        is_hi;
		logic        is_lo;
		status_t     st;
		if (!odd_phase) begin
			// a last byte in low position means odd length, whatever came before
			if (bi.last_byte) begin
				push_item(16'h0000, 1'b1, ST_ODD, 1'b1);
				restart_payload();
			end else begin
				low_byte  = bi.data_byte;
				odd_phase = 1'b1;
			end
		end else begin
			u         = {bi.data_byte, low_byte};
			is_hi     = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
			is_lo     = (u >= LOW_FIRST) && (u <= LOW_LAST);
			odd_phase = 1'b0;
			low_byte  = 8'h00;
			// after the first error units are only paired and dropped
			if (latched_err == ST_OK) begin
				if (high_waiting) begin
					if (is_lo) begin
						// pair goes out only when it is not the closing unit
						if (!bi.last_byte) begin
							push_item(held_high, 1'b0, ST_OK, 1'b0);
							push_item(u, 1'b0, ST_OK, 1'b1);
						end
						high_waiting = 1'b0;
						held_high    = 16'h0000;
					end else begin
						latched_err = ST_BAD_PAIR;
					end
				end else if (nul_seen) begin
					if (u != NUL_UNIT)
						latched_err = ST_AFTER_NUL;
				end else if (u == NUL_UNIT) begin
					nul_seen = 1'b1;
				end else if (is_hi) begin
					held_high    = u;
					high_waiting = 1'b1;
				end else if (is_lo) begin
					latched_err = ST_LONE_LOW;
				end else if (!bi.last_byte) begin
					push_item(u, 1'b0, ST_OK, 1'b1);
				end
			end
			// closing status: latched error, then open pair, then missing nul
			if (bi.last_byte) begin
				if (latched_err != ST_OK)
					st = latched_err;
				else if (high_waiting)
					st = ST_HIGH_END;
				else if (!nul_seen)
					st = ST_NO_NUL;
				else
					st = ST_OK;
				push_item(16'h0000, 1'b1, st, 1'b1);
				restart_payload();
			end
		end
	endtask

	// predict on byte handshakes, compare on result handshakes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_payload();
			due_items = {};
			items_owed = 0;
		end else begin
			if (byte_valid && byte_ready)
				decode_byte(byte_item);
			if (res_valid && res_ready) begin
				if (due_items.size() == 0) begin
					fails++;
					$display("%0t: unexpected item: unit %h kind %0d status %0d eor %0d",
						$time, res_item.code_unit, res_item.kind, res_item.status,
						res_item.end_of_run);
				end else begin
					want = due_items.pop_front();
					if (res_item.code_unit !== want.code_unit) begin
						fails++;
						$display("%0t: code_unit mismatch: expected %h, got %h",
							$time, want.code_unit, res_item.code_unit);
					end
					if (res_item.kind !== want.kind) begin
						fails++;
						$display("%0t: kind mismatch: expected %0d, got %0d",
							$time, want.kind, res_item.kind);
					end
					if (res_item.status !== want.status) begin
						fails++;
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, res_item.status);
					end
					if (res_item.end_of_run !== want.end_of_run) begin
						fails++;
						$display("%0t: end_of_run mismatch: expected %0d, got %0d",
							$time, want.end_of_run, res_item.end_of_run);
					end
				end
			end
			items_owed = due_items.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
	import u16d_pkg::*;

	localparam int RUN_LIMIT    = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 1900;
	localparam int CALM_TAIL    = 250;
	localparam int DRAIN_CYCLES = 20;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_ready;
	in_item_t  byte_item;
	logic      res_valid;
	logic      res_ready;
	out_item_t res_item;

	int          items_owed;
	int          fails;
	int          cycle_cnt;
	int          sent_bytes;
	bit          src_idle;
	bit          sink_idle;
	bit          hold_req;
	bit          hold_done;
	logic [15:0] units[$];
	logic [7:0]  bytes_q[$];

	utf16le_validating_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	u16d_stream_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.items_owed (items_owed),
		.fails      (fails)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off
	initial begin
		int stall_left;
		bit hold_taken;
		stall_left = 0;
		hold_taken = 1'b0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				res_ready <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 13);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	function automatic logic [15:0] rand_plain();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(1, 127));
			1: return 16'($urandom_range(16'h0080, 16'hD7FF));
			default: return 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] rand_high();
		return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
	endfunction

	function automatic logic [15:0] rand_low();
		return 16'($urandom_range(LOW_FIRST, LOW_LAST));
	endfunction

	// offer one byte and hold it until taken; valid stays up afterwards
	task automatic send_byte(input logic [7:0] d, input logic l);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item.data_byte <= d;
		byte_item.last_byte <= l;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		sent_bytes++;
	endtask

	task automatic send_payload();
		foreach (bytes_q[i])
			send_byte(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	task automatic units_to_bytes();
		foreach (units[i]) begin
			bytes_q.insert(bytes_q.size(), units[i][7:0]);
			bytes_q.insert(bytes_q.size(), units[i][15:8]);
		end
	endtask

	// stop offering and wait until every predicted item has come out
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(negedge clk);
		wait (items_owed == 0);
		@(posedge clk);
	endtask

	// mostly well-formed text, with broken endings and raw byte noise mixed in
	task automatic random_payload();
		int          nbody;
		int          pick;
		int          pos;
		logic [15:0] u;
		units = {};
		bytes_q = {};
		pick = $urandom_range(0, 99);
		if (pick >= 90) begin
			repeat ($urandom_range(1, 16))
				bytes_q.insert(bytes_q.size(), ($urandom_range(0, 2) == 0) ?
					8'($urandom_range(8'hD8, 8'hDF)) : 8'($urandom));
		end else begin
			nbody = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
				$urandom_range(0, 8);
			repeat (nbody) begin
				if ($urandom_range(0, 3) == 0) begin
					units.insert(units.size(), rand_high());
					units.insert(units.size(), rand_low());
				end else begin
					units.insert(units.size(), rand_plain());
				end
			end
			pos = $urandom_range(0, units.size());
			if (pick < 55) begin
				units.insert(units.size(), NUL_UNIT);
				repeat ($urandom_range(0, 2)) units.insert(units.size(), NUL_UNIT);
			end else if (pick < 60) begin
				units.insert(units.size(), rand_high());
			end else if (pick < 66) begin
				units.insert(units.size(), rand_plain());
			end else if (pick < 72) begin
				units.insert(pos, rand_low());
				units.insert(units.size(), NUL_UNIT);
			end else if (pick < 78) begin
				// high followed by something that is not a low half
				case ($urandom_range(0, 2))
					0: u = rand_plain();
					1: u = rand_high();
					default: u = NUL_UNIT;
				endcase
				units.insert(pos, u);
				units.insert(pos, rand_high());
				units.insert(units.size(), NUL_UNIT);
			end else if (pick < 85) begin
				units.insert(units.size(), NUL_UNIT);
				units.insert(units.size(),
					($urandom_range(0, 1) == 0) ? rand_plain() : rand_low());
				repeat ($urandom_range(0, 3)) units.insert(units.size(), 16'($urandom));
			end else begin
				units.insert(units.size(), rand_low());
			end
			units_to_bytes();
			if ($urandom_range(0, 9) == 0)
				bytes_q.insert(bytes_q.size(), 8'($urandom));
		end
		send_payload();
	endtask

	// stimulus
	initial begin
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		byte_item  <= '0;
		sent_bytes = 0;
		src_idle   = 1'b1;
		sink_idle  = 1'b1;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone byte is an odd length
		bytes_q = {8'hFF};
		send_payload();
		// largest unit, then nul
		bytes_q = {8'hFF, 8'hFF, 8'h00, 8'h00};
		send_payload();
		// lowest high with highest low, then nul
		bytes_q = {8'h00, 8'hD8, 8'hFF, 8'hDF, 8'h00, 8'h00};
		send_payload();
		// unit closing the payload without a nul
		bytes_q = {8'hFF, 8'hFF};
		send_payload();
		// lone low latched, odd length still wins
		bytes_q = {8'h00, 8'hDC, 8'h01};
		send_payload();
		// high half open at the end
		bytes_q = {8'hFF, 8'hDB};
		send_payload();
		// nonzero unit after nul
		bytes_q = {8'h00, 8'h00, 8'h01, 8'h00};
		send_payload();
		// high followed by a plain unit
		bytes_q = {8'h00, 8'hD8, 8'h41, 8'h00};
		send_payload();
		wait_drained();

		while (sent_bytes < RANDOM_BYTES) begin
			if (sent_bytes > RANDOM_BYTES - CALM_TAIL) begin
				src_idle  = 1'b0;
				sink_idle = 1'b0;
			end else begin
				src_idle  = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
			end
			if (!hold_done && sent_bytes > RANDOM_BYTES / 3) begin
				// results back up while bytes keep coming
				hold_done = 1'b1;
				wait_drained();
				hold_req = 1'b1;
				src_idle = 1'b0;
				units = {};
				bytes_q = {};
				repeat (30) units.insert(units.size(), rand_plain());
				units.insert(units.size(), NUL_UNIT);
				units_to_bytes();
				send_payload();
			end
			random_payload();
			if ($urandom_range(0, 24) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && items_owed == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
